@@ hdl/sem_pkg.sv @@
package sem_pkg;

  // line store depth and derived widths
  localparam int MAX_WIDTH = 1024;
  localparam int COL_W     = $clog2(MAX_WIDTH);

  // register and pixel widths
  localparam int FW_W  = 11;
  localparam int FH_W  = 12;
  localparam int PIX_W = 8;
  localparam int SUM_W = 10;

  localparam logic [FW_W-1:0] WIDTH_RESET  = 11'd640;
  localparam logic [FH_W-1:0] HEIGHT_RESET = 12'd480;
  localparam logic [FW_W-1:0] WIDTH_MIN    = 11'd3;
  localparam logic [FW_W-1:0] WIDTH_MAX    = FW_W'(MAX_WIDTH);
  localparam logic [FH_W-1:0] HEIGHT_MIN   = 12'd3;

  // register map: index taken from paddr[2]
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // divide by three: (x * 683) >> 11 is exact for x below 2048
  localparam logic [SUM_W-1:0] DIV3_MUL   = 10'd683;
  localparam int               DIV3_SHIFT = 11;
  localparam int               PROD_W     = 2 * SUM_W;

  // column queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = Q_PTR_W + 1;

  // gradient and root widths
  localparam int GRAD_W          = 10;
  localparam int SQ_W            = 2 * GRAD_W;
  localparam int SSUM_W          = SQ_W + 1;
  localparam int RAD_W           = 16;
  localparam int ROOT_W          = 8;
  localparam int REM_W           = 10;
  localparam int SQRT_STAGES     = 4;
  localparam int STEPS_PER_STAGE = 2;

  // 255 squared: anything at or above saturates
  localparam logic [SSUM_W-1:0] SAT_LIMIT = 21'd65025;
  localparam logic [ROOT_W-1:0] MAG_MAX   = 8'd255;

  typedef struct packed {
    logic [FW_W-1:0] width;
    logic [FH_W-1:0] height;
  } frame_cfg_t;

  typedef struct packed {
    logic [PIX_W-1:0] upper;
    logic [PIX_W-1:0] middle;
    logic [PIX_W-1:0] lower;
  } pix_col_t;

  typedef struct packed {
    pix_col_t pix;
    logic     emit;
    logic     last;
  } col_item_t;

  typedef struct packed {
    logic full;
    logic almost_full;
    logic empty;
  } q_status_t;

  typedef struct packed {
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_acc_t;

  function automatic logic [PIX_W-1:0] gray_of(input logic [PIX_W-1:0] r,
                                                input logic [PIX_W-1:0] g,
                                                input logic [PIX_W-1:0] b);
    logic [SUM_W-1:0]  sum;
    logic [PROD_W-1:0] prod;
    sum  = SUM_W'(r) + SUM_W'(g) + SUM_W'(b);
    prod = PROD_W'(sum) * PROD_W'(DIV3_MUL);
    return prod[DIV3_SHIFT +: PIX_W];
  endfunction

  // a + 2b + c
  function automatic logic [GRAD_W-1:0] wsum(input logic [PIX_W-1:0] a,
                                             input logic [PIX_W-1:0] b,
                                             input logic [PIX_W-1:0] c);
    return GRAD_W'(a) + GRAD_W'({b, 1'b0}) + GRAD_W'(c);
  endfunction

  function automatic logic [GRAD_W-1:0] absdiff(input logic [GRAD_W-1:0] p,
                                                input logic [GRAD_W-1:0] q);
    return (p >= q) ? (p - q) : (q - p);
  endfunction

  // one digit of the restoring square root, two radicand bits a step
  function automatic sqrt_acc_t sqrt_step(input sqrt_acc_t acc, input logic [1:0] pair);
    logic [REM_W+1:0] trial;
    logic [REM_W+1:0] part;
    sqrt_acc_t        res;
    part  = {acc.rem, pair};
    trial = (REM_W + 2)'({acc.root, 2'b01});
    if (part >= trial) begin
      res.rem  = REM_W'(part - trial);
      res.root = {acc.root[ROOT_W-2:0], 1'b1};
    end else begin
      res.rem  = part[REM_W-1:0];
      res.root = {acc.root[ROOT_W-2:0], 1'b0};
    end
    return res;
  endfunction

endpackage

@@ hdl/sem_front.sv @@
module sem_front
  import sem_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  frame_cfg_t       frame_cfg,
  input  logic             restart,
  input  logic             pix_valid,
  output logic             pix_ready,
  input  logic [PIX_W-1:0] red,
  input  logic [PIX_W-1:0] green,
  input  logic [PIX_W-1:0] blue,
  input  q_status_t        q_status,
  output logic             push,
  output col_item_t        push_item
);

  logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
  logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

  logic [COL_W-1:0] col_r, col_nxt;
  logic [FH_W-1:0]  row_r, row_nxt;
  logic             s_vld_r;
  logic [COL_W-1:0] s_col_r;
  logic [PIX_W-1:0] s_gray_r;
  logic             s_emit_r;
  logic             s_last_r;
  logic [PIX_W-1:0] upper_q_r;
  logic [PIX_W-1:0] middle_q_r;

  logic [FW_W-1:0]  w_eff;
  logic [FW_W-1:0]  w_last;
  logic [FH_W-1:0]  h_eff;
  logic [FH_W-1:0]  h_last;
  logic             accept;
  logic             row_end;
  logic             frame_end;

  always_comb begin
    priority if (frame_cfg.width < WIDTH_MIN) begin
      w_eff = WIDTH_MIN;
    end else if (frame_cfg.width > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end else begin
      w_eff = frame_cfg.width;
    end
    h_eff  = (frame_cfg.height < HEIGHT_MIN) ? HEIGHT_MIN : frame_cfg.height;
    w_last = w_eff - 1'b1;
    h_last = h_eff - 1'b1;
  end

  // keep a slot for the item still in the read stage
  assign pix_ready = !(q_status.full || (q_status.almost_full && s_vld_r));
  assign accept    = pix_valid && pix_ready;
  assign row_end   = (col_r == w_last[COL_W-1:0]);
  assign frame_end = row_end && (row_r == h_last);

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    priority if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (accept) begin
      if (row_end) begin
        col_nxt = '0;
        row_nxt = frame_end ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      s_vld_r <= 1'b0;
    end else begin
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      s_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_col_r  <= col_r;
      s_gray_r <= gray_of(red, green, blue);
      s_emit_r <= (row_r >= FH_W'(2)) && (col_r >= COL_W'(2));
      s_last_r <= frame_end;
    end
  end

  // line stores: read on accept, rotate in the following cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      upper_q_r <= upper_mem[col_r];
    end
    if (s_vld_r) begin
      upper_mem[s_col_r] <= middle_q_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      middle_q_r <= middle_mem[col_r];
    end
    if (s_vld_r) begin
      middle_mem[s_col_r] <= s_gray_r;
    end
  end

  assign push                = s_vld_r;
  assign push_item.pix.upper  = upper_q_r;
  assign push_item.pix.middle = middle_q_r;
  assign push_item.pix.lower  = s_gray_r;
  assign push_item.emit       = s_emit_r;
  assign push_item.last       = s_last_r;

`ifndef SYNTH
  a_col_step: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !restart && !row_end) |=> (col_r == $past(col_r) + 1'b1))
    else $error("column count did not advance");
`endif

endmodule

@@ hdl/sem_queue.sv @@
module sem_queue
  import sem_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  col_item_t push_item,
  input  logic      pop,
  output col_item_t pop_item,
  output q_status_t q_status
);

  col_item_t          slot_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

  assign pop_item             = slot_r[rd_ptr_r];
  assign q_status.full        = (count_r == Q_CNT_W'(Q_DEPTH));
  assign q_status.almost_full = (count_r >= Q_CNT_W'(Q_DEPTH - 1));
  assign q_status.empty       = (count_r == '0);

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_status.full)
    else $error("push into full column queue");
  a_fill_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue fill count out of step");
`endif

endmodule

@@ hdl/sem_back.sv @@
module sem_back
  import sem_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  q_status_t         q_status,
  input  col_item_t         pop_item,
  output logic              pop,
  output logic              mag_valid,
  input  logic              mag_ready,
  output logic [ROOT_W-1:0] mag,
  output logic              mag_last
);

  pix_col_t           win0_r, win1_r;

  logic               s1_vld_r;
  logic [GRAD_W-1:0]  s1_sx_r, s1_sy_r;
  logic               s1_last_r;

  logic               s2_vld_r;
  logic [SQ_W-1:0]    s2_sqx_r, s2_sqy_r;
  logic               s2_last_r;

  logic               s3_vld_r;
  logic [RAD_W-1:0]   s3_rad_r;
  logic               s3_sat_r;
  logic               s3_last_r;

  logic               sq_vld_r  [SQRT_STAGES];
  sqrt_acc_t          sq_acc_r  [SQRT_STAGES];
  logic [RAD_W-1:0]   sq_rad_r  [SQRT_STAGES];
  logic               sq_sat_r  [SQRT_STAGES];
  logic               sq_last_r [SQRT_STAGES];

  logic               out_vld_r;
  logic [ROOT_W-1:0]  out_mag_r;
  logic               out_last_r;

  logic               en;
  logic [SSUM_W-1:0]  sq_sum;
  pix_col_t           cur;

  // whole pipeline moves when the output register is free or being taken
  assign en  = !out_vld_r || mag_ready;
  assign pop = en && !q_status.empty;
  assign cur = pop_item.pix;

  // window shifts on every column, interior or not
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win0_r <= '0;
      win1_r <= '0;
    end else if (pop) begin
      win0_r <= win1_r;
      win1_r <= cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= pop && pop_item.emit;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
  end

  assign sq_sum = SSUM_W'(s2_sqx_r) + SSUM_W'(s2_sqy_r);

  always_ff @(posedge clk) begin
    if (en) begin
      // gx: right column minus left, gy: bottom row minus top
      s1_sx_r   <= absdiff(wsum(cur.upper, cur.middle, cur.lower),
                           wsum(win0_r.upper, win0_r.middle, win0_r.lower));
      s1_sy_r   <= absdiff(wsum(win0_r.lower, win1_r.lower, cur.lower),
                           wsum(win0_r.upper, win1_r.upper, cur.upper));
      s1_last_r <= pop_item.last;
      s2_sqx_r  <= SQ_W'(s1_sx_r) * SQ_W'(s1_sx_r);
      s2_sqy_r  <= SQ_W'(s1_sy_r) * SQ_W'(s1_sy_r);
      s2_last_r <= s1_last_r;
      s3_rad_r  <= sq_sum[RAD_W-1:0];
      s3_sat_r  <= (sq_sum >= SAT_LIMIT);
      s3_last_r <= s2_last_r;
    end
  end

  // square root, two digits per stage
  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    sqrt_acc_t        acc_in, acc_out;
    logic [RAD_W-1:0] rad_in;
    logic             vld_in, sat_in, last_in;

    if (k == 0) begin : g_first
      assign vld_in  = s3_vld_r;
      assign acc_in  = '0;
      assign rad_in  = s3_rad_r;
      assign sat_in  = s3_sat_r;
      assign last_in = s3_last_r;
    end else begin : g_next
      assign vld_in  = sq_vld_r[k-1];
      assign acc_in  = sq_acc_r[k-1];
      assign rad_in  = sq_rad_r[k-1];
      assign sat_in  = sq_sat_r[k-1];
      assign last_in = sq_last_r[k-1];
    end

    always_comb begin
      acc_out = acc_in;
      for (int j = 0; j < STEPS_PER_STAGE; j++) begin
        acc_out = sqrt_step(acc_out, rad_in[RAD_W-1-2*j -: 2]);
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[k] <= 1'b0;
      end else if (en) begin
        sq_vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_acc_r[k]  <= acc_out;
        sq_rad_r[k]  <= rad_in << (2 * STEPS_PER_STAGE);
        sq_sat_r[k]  <= sat_in;
        sq_last_r[k] <= last_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= sq_vld_r[SQRT_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mag_r  <= sq_sat_r[SQRT_STAGES-1] ? MAG_MAX : sq_acc_r[SQRT_STAGES-1].root;
      out_last_r <= sq_last_r[SQRT_STAGES-1];
    end
  end

  assign mag_valid = out_vld_r;
  assign mag       = out_mag_r;
  assign mag_last  = out_last_r;

`ifndef SYNTH
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> ($stable(sq_vld_r[SQRT_STAGES-1]) && $stable(s3_vld_r)))
    else $error("back pipeline moved while stalled");
`endif

endmodule

@@ hdl/sobel_edge_magnitude.sv @@
// sobel edge magnitude, 3x3 window over a raster pixel stream
//
// in_*   : one rgb pixel per word, raster order; each is reduced to gray
// out_*  : one clamped gradient magnitude per interior pixel, tlast on the
//          last interior pixel of the frame; border pixels give no word
// cfg_*  : apb registers, frame_width at 0x0 and frame_height at 0x4;
//          a write to either restarts the frame at row 0, column 0
//
// a word is taken every cycle while the column queue has room; the front
// end reads both line stores in the accept cycle and rotates them the next
// cycle. a magnitude passes from its completing pixel through the line
// store read, a queue slot, gradient, squares, sum and clamp, four root
// stages and the output register.
// when the receiver holds out_tready low the back end freezes, the queue
// fills and in_tready drops after at most four more words.
// reset clears counters, queue and pipeline valids and loads 640 x 480;
// line store contents are not cleared and feed a magnitude only once written
module sobel_edge_magnitude
  import sem_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,     // red [7:0], green [15:8], blue [23:16]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,    // magnitude [7:0]
  output logic        out_tlast,    // frame_last
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  frame_cfg_t frame_cfg_r;
  logic       cfg_wr;
  logic       reg_sel;

  logic       push;
  col_item_t  push_item;
  logic       pop;
  col_item_t  pop_item;
  q_status_t  q_status;

  // register port, zero wait states
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_cfg_r.width  <= WIDTH_RESET;
      frame_cfg_r.height <= HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (reg_sel)
        REG_WIDTH:  frame_cfg_r.width  <= cfg_pwdata[FW_W-1:0];
        REG_HEIGHT: frame_cfg_r.height <= cfg_pwdata[FH_W-1:0];
        default:    frame_cfg_r        <= frame_cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_WIDTH:  cfg_prdata = 32'(frame_cfg_r.width);
      REG_HEIGHT: cfg_prdata = 32'(frame_cfg_r.height);
      default:    cfg_prdata = '0;
    endcase
  end

  // front: position counters, grayscale, line stores
  sem_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .frame_cfg (frame_cfg_r),
    .restart   (cfg_wr),
    .pix_valid (in_tvalid),
    .pix_ready (in_tready),
    .red       (in_tdata[7:0]),
    .green     (in_tdata[15:8]),
    .blue      (in_tdata[23:16]),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  // short column queue between the two halves
  sem_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_status  (q_status)
  );

  // back: window, gradients, root and output register
  sem_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_status  (q_status),
    .pop_item  (pop_item),
    .pop       (pop),
    .mag_valid (out_tvalid),
    .mag_ready (out_tready),
    .mag       (out_tdata),
    .mag_last  (out_tlast)
  );

endmodule

@@ tb/sobel_edge_magnitude_test.sv @@
`timescale 1ns / 100ps

module sobel_edge_magnitude_test;
  import sem_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 16;
  localparam int REPORT_MAX     = 10;
  localparam int DIRECTED_COUNT = 20;

  // hand-picked 4x4 frame plus the start of the next one, {blue, green, red}
  localparam logic [DIRECTED_COUNT*24-1:0] DIRECTED_PIXELS = {
    24'h000000, 24'hFFFFFF, 24'hFEFFFF, 24'h0000FF,
    24'h00FF00, 24'hFF0000, 24'hFFFFFF, 24'h000000,
    24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF,
    24'h010101, 24'h808080, 24'hFFFFFF, 24'h000000,
    24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h7F7F7F
  };

  typedef enum int {PIX_RANDOM, PIX_RAMP, PIX_BINARY, PIX_DIM} pix_style_t;
  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [7:0] magnitude;
    logic       frame_last;
  } edge_result_t;

  // every input is known from time zero
  logic        clk         = 1'b0;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = '0;
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [7:0]  out_tdata;
  logic        out_tlast;
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [2:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // pixels waiting for the driver, magnitudes waiting for the block
  logic [23:0]  pixel_q[$];
  edge_result_t edge_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int mismatches     = 0;
  int quiet_cycles   = 0;

  // predictor copy of the block's registers and stores
  logic [FW_W-1:0]  width_reg  = WIDTH_RESET;
  logic [FH_W-1:0]  height_reg = HEIGHT_RESET;
  logic [7:0]       upper_row [MAX_WIDTH];
  logic [7:0]       middle_row [MAX_WIDTH];
  logic [7:0]       prev_cols [6] = '{default: 8'd0};
  int               col_pos = 0;
  int               row_pos = 0;

  sobel_edge_magnitude u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    if (mismatches < REPORT_MAX) begin
      $display("mismatch on %s: expected %0d, got %0d", what, want, got);
    end
    mismatches++;
  endfunction

  // floor square root of a value below 255 squared, one bit at a time
  function automatic int unsigned root_floor(input int unsigned v);
    int unsigned root;
    int unsigned trial;
    root = 0;
    for (int b = 7; b >= 0; b--) begin
      trial = root | (1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // one pixel through the predictor; queues a magnitude for interior pixels
  function automatic void predict_edge(input logic [23:0] word);
    int           w;
    int           h;
    int           col;
    int           gray;
    int           sx;
    int           sy;
    int unsigned  sq;
    logic [7:0]   t [3];
    logic [7:0]   m [3];
    logic [7:0]   b [3];
    bit           row_end;
    bit           frame_end;
    edge_result_t res;

    // out-of-range registers saturate
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = (height_reg < 3) ? 3 : height_reg;
    col = (col_pos >= w) ? w - 1 : col_pos;

    gray = (int'(word[7:0]) + int'(word[15:8]) + int'(word[23:16])) / 3;

    // window columns: 0 two back, 1 one back, 2 current
    t[0] = prev_cols[0];
    m[0] = prev_cols[1];
    b[0] = prev_cols[2];
    t[1] = prev_cols[3];
    m[1] = prev_cols[4];
    b[1] = prev_cols[5];
    t[2] = upper_row[col];
    m[2] = middle_row[col];
    b[2] = gray[7:0];

    upper_row[col]  = middle_row[col];
    middle_row[col] = gray[7:0];
    prev_cols = '{t[1], m[1], b[1], t[2], m[2], b[2]};

    row_end   = (col_pos >= w - 1);
    frame_end = row_end && (row_pos >= h - 1);

    if (row_pos >= 2 && col >= 2) begin
      sx = (int'(t[2]) + 2 * int'(m[2]) + int'(b[2]))
         - (int'(t[0]) + 2 * int'(m[0]) + int'(b[0]));
      sy = (int'(b[0]) + 2 * int'(b[1]) + int'(b[2]))
         - (int'(t[0]) + 2 * int'(t[1]) + int'(t[2]));
      sq = sx * sx + sy * sy;
      res.magnitude  = (sq >= 65025) ? 8'd255 : 8'(root_floor(sq));
      res.frame_last = frame_end;
      edge_q.push_back(res);
    end

    if (row_end) begin
      col_pos = 0;
      row_pos = frame_end ? 0 : row_pos + 1;
    end else begin
      col_pos++;
    end
  endfunction

  function automatic logic [23:0] make_pixel(input pix_style_t style, input int idx);
    logic [7:0] level;
    case (style)
      PIX_RAMP: begin
        // slow ramp with a little noise; gradients stay small except where it wraps
        level = 8'((idx * 5) % 250);
        return {level + 8'($urandom_range(0, 5)), level + 8'($urandom_range(0, 5)),
                level + 8'($urandom_range(0, 5))};
      end
      PIX_BINARY: begin
        level = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        return {3{level}};
      end
      PIX_DIM: begin
        return {8'($urandom_range(0, 31)), 8'($urandom_range(0, 31)),
                8'($urandom_range(0, 31))};
      end
      default: begin
        return 24'($urandom);
      end
    endcase
  endfunction

  // driver: one word in flight, refilled from pixel_q as the block takes it
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) predict_edge(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (pixel_q.size() != 0 && int'($urandom_range(0, 99)) >= send_idle_pct) begin
          in_tdata  <= pixel_q.pop_front();
          in_tvalid <= 1'b1;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    out_tready <= int'($urandom_range(0, 99)) >= recv_stall_pct;
  end

  // monitor: each magnitude word against the oldest prediction
  always @(posedge clk) begin : check_results
    edge_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (edge_q.size() == 0) begin
        note_mismatch("unexpected magnitude word", 32'hFFFF_FFFF, 32'(out_tdata));
      end else begin
        want = edge_q.pop_front();
        if (out_tdata !== want.magnitude) begin
          note_mismatch("magnitude", 32'(want.magnitude), 32'(out_tdata));
        end
        if (out_tlast !== want.frame_last) begin
          note_mismatch("frame_last", 32'(want.frame_last), 32'(out_tlast));
        end
      end
    end
  end

  // watchdog: too long with no word moving on any port
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("sobel_edge_magnitude verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // apb: setup cycle, access cycle, done at the edge with pready high
  task automatic cfg_access(input logic idx, input logic write, input logic [31:0] wdata,
                            output logic [31:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= write;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic check_register(input logic idx);
    logic [31:0] rdata;
    cfg_access(idx, 1'b0, '0, rdata);
    if (idx == REG_WIDTH) begin
      if (rdata[FW_W-1:0] !== width_reg) note_mismatch("frame_width read", 32'(width_reg),
                                                       32'(rdata[FW_W-1:0]));
    end else begin
      if (rdata[FH_W-1:0] !== height_reg) note_mismatch("frame_height read", 32'(height_reg),
                                                        32'(rdata[FH_W-1:0]));
    end
  endtask

  // a write restarts the frame in the block, so the predictor follows
  task automatic set_register(input logic idx, input logic [31:0] value);
    logic [31:0] unused;
    cfg_access(idx, 1'b1, value, unused);
    if (idx == REG_WIDTH) width_reg = value[FW_W-1:0];
    else height_reg = value[FH_W-1:0];
    col_pos = 0;
    row_pos = 0;
    check_register(idx);
  endtask

  // every word sent, every magnitude back, then room for border pixels
  // still in the pipe to finish their line store writes
  task automatic wait_drained();
    while (pixel_q.size() != 0 || in_tvalid || edge_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SEND: begin
        send_idle_pct  = 70;
        recv_stall_pct = 0;
      end
      IDLE_RECV: begin
        send_idle_pct  = 0;
        recv_stall_pct = 70;
      end
      IDLE_BOTH: begin
        send_idle_pct  = 20;
        recv_stall_pct = 20;
      end
      default: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  task automatic run_phase(input int width, input int height, input int count,
                           input pix_style_t style, input idle_mode_t mode);
    set_idling(mode);
    set_register(REG_WIDTH, width);
    set_register(REG_HEIGHT, height);
    for (int i = 0; i < count; i++) pixel_q.push_back(make_pixel(style, i));
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset values of both registers
    check_register(REG_WIDTH);
    check_register(REG_HEIGHT);

    // directed: tiny frame with extreme and single-channel pixels, then a wrap
    set_idling(IDLE_NONE);
    set_register(REG_WIDTH, 4);
    set_register(REG_HEIGHT, 4);
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      pixel_q.push_back(DIRECTED_PIXELS[(DIRECTED_COUNT - 1 - i) * 24 +: 24]);
    end
    wait_drained();

    // registers below range saturate to the smallest frame
    run_phase(0, 0, 180, PIX_RANDOM, IDLE_SEND);
    run_phase(2, 1, 90, PIX_BINARY, IDLE_RECV);
    run_phase(3, 3, 90, PIX_DIM, IDLE_BOTH);
    run_phase(5, 4095, 150, PIX_RAMP, IDLE_NONE);
    run_phase(17, 6, 204, PIX_RANDOM, IDLE_SEND);
    // widest frame: exact limit written, then a value above it that saturates
    run_phase(1024, 4095, 0, PIX_RANDOM, IDLE_NONE);
    run_phase(2047, 3, 260, PIX_RAMP, IDLE_BOTH);
    run_phase(64, 5, 330, PIX_DIM, IDLE_RECV);
    run_phase(1, 2, 60, PIX_RANDOM, IDLE_BOTH);

    // a few random small geometries
    run_phase($urandom_range(3, 40), $urandom_range(3, 9), $urandom_range(100, 250),
              PIX_RANDOM, IDLE_NONE);
    run_phase($urandom_range(3, 40), $urandom_range(3, 9), $urandom_range(100, 250),
              PIX_RAMP, IDLE_SEND);
    run_phase($urandom_range(3, 40), $urandom_range(3, 9), $urandom_range(100, 250),
              PIX_BINARY, IDLE_RECV);

    wait_drained();
    if (mismatches == 0 && edge_q.size() == 0) begin
      $display("sobel_edge_magnitude verification clean");
    end else begin
      $display("sobel_edge_magnitude verification failed");
    end
    $finish;
  end

endmodule
